// File: rtl/gsst_pkg.sv
// gsst_pkg: shared types, field widths and codes of the generational sparse-set table
// depends on nothing; compiled first
`timescale 1ns / 1ps

package gsst_pkg;

  localparam int unsigned SPARSE_DEPTH_DEF = 1024;
  localparam int unsigned ROW_DEPTH_DEF    = 256;

  localparam int IDX_W   = 10;
  localparam int GEN_W   = 16;
  localparam int KEY_W   = 32;
  localparam int DIM_W   = 8;
  localparam int FST_W   = 4;
  localparam int DIX_W   = 8;
  localparam int FOUND_W = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    MODE_APPEND    = 2'd0,
    MODE_READ      = 2'd1,
    MODE_FIND      = 2'd2,
    MODE_SET_STATE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_DUP     = 3'd2,
    STS_RANGE   = 3'd3,
    STS_MISS    = 3'd4,
    STS_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_ROW
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   entity_index;
    logic [GEN_W-1:0]   generation;
    logic [KEY_W-1:0]   kind_key;
    logic [DIM_W-1:0]   dimension;
    logic               buildable;
    logic [FST_W-1:0]   fac_state;
    logic [DIX_W-1:0]   dense_index;
  } req_t;

  typedef struct packed {
    logic [GEN_W-1:0]   generation;
    logic [IDX_W-1:0]   entity_index;
    logic [KEY_W-1:0]   kind_key;
    logic [DIM_W-1:0]   dimension;
    logic               buildable;
    logic [FST_W-1:0]   fac_state;
  } row_t;

endpackage

// File: rtl/gsst_if.sv
// gsst_req_if / gsst_rsp_if: valid/ready channels of the sparse-set table
// depends on gsst_pkg
`timescale 1ns / 1ps

interface gsst_req_if;
  import gsst_pkg::*;

  logic               valid;
  logic               ready;
  mode_t              mode;
  logic [IDX_W-1:0]   entity_index;
  logic [GEN_W-1:0]   generation;
  logic [KEY_W-1:0]   kind_key;
  logic [DIM_W-1:0]   dimension;
  logic               buildable;
  logic [FST_W-1:0]   fac_state;
  logic [DIX_W-1:0]   dense_index;

  modport source (
    output valid, mode, entity_index, generation, kind_key, dimension, buildable,
           fac_state, dense_index,
    input  ready
  );
  modport sink (
    input  valid, mode, entity_index, generation, kind_key, dimension, buildable,
           fac_state, dense_index,
    output ready
  );
endinterface

interface gsst_rsp_if;
  import gsst_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [FOUND_W-1:0]   found_index;
  logic [IDX_W-1:0]     row_entity_index;
  logic [GEN_W-1:0]     row_generation;
  logic [KEY_W-1:0]     row_kind_key;
  logic [DIM_W-1:0]     row_dimension;
  logic                 row_buildable;
  logic [FST_W-1:0]     row_state;
  logic [COUNT_W-1:0]   row_count;

  modport source (
    output valid, status, found_index, row_entity_index, row_generation, row_kind_key,
           row_dimension, row_buildable, row_state, row_count,
    input  ready
  );
  modport sink (
    input  valid, status, found_index, row_entity_index, row_generation, row_kind_key,
           row_dimension, row_buildable, row_state, row_count,
    output ready
  );
endinterface

// File: rtl/generational_sparse_set_table.sv
// generational_sparse_set_table: top level, sparse map and dense row memories
// depends on gsst_pkg and the channel interfaces in gsst_if.sv
//
// usage
//   req carries one operation per transaction: append a row, read a row by dense
//   index, find an id, or set the state of a found row. rsp returns exactly one
//   result per request, in order, always with the row count after the operation.
// timing
//   the sparse map is read at the accepting edge, the dense row memory in the look
//   state, and the result is registered into the output register from the row
//   stage once that register is free or being emptied. Those two dependent memory
//   reads keep one transaction in flight at a time: a new request is taken in
//   the cycle the previous one writes back.
// reset
//   rst clears the control state and starts a clearing pass over the SPARSE_DEPTH
//   entries of the sparse map (1024 by default), with req.ready low throughout.
// stalls
//   a finished result waits in the output register; the next request is still
//   taken and worked on, and it holds in its last cycle until that register frees.
`timescale 1ns / 1ps

module generational_sparse_set_table #(
  parameter int unsigned SPARSE_DEPTH = gsst_pkg::SPARSE_DEPTH_DEF,
  parameter int unsigned ROW_DEPTH    = gsst_pkg::ROW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gsst_req_if.sink   req,
  gsst_rsp_if.source rsp
);
  import gsst_pkg::*;

  localparam int unsigned SAW = $clog2(SPARSE_DEPTH);   // sparse map address
  localparam int unsigned RAW = $clog2(ROW_DEPTH);      // dense slot
  localparam int unsigned CW  = $clog2(ROW_DEPTH + 1);  // row count

  // sparse map entry: valid bit on top, dense slot below
  logic [RAW:0]     sparse_mem [SPARSE_DEPTH];
  row_t             row_mem    [ROW_DEPTH];

  state_t           state, state_next;
  logic [SAW-1:0]   clr_addr;
  logic             clr_last;
  logic [CW-1:0]    count;

  req_t             q;              // transaction being worked on
  req_t             req_word;
  logic [RAW:0]     sparse_rd;      // registered sparse read data
  logic [RAW:0]     sp;             // sparse entry after forwarding, held for row stage
  logic [RAW:0]     sp_eff;
  logic             fwd_hit;        // write-back of previous append hit this address
  logic [RAW:0]     fwd_data;
  row_t             row_rd;         // registered row read data
  logic [RAW-1:0]   row_raddr;

  logic             accept;
  logic             finish;

  // result and write-back of the row stage
  status_t          res_status;
  logic [FOUND_W-1:0] res_found;
  row_t             res_row;
  logic             sp_we;
  logic [SAW-1:0]   sp_waddr;
  logic [RAW:0]     sp_wdata;
  logic             row_we;
  logic [RAW-1:0]   row_waddr;
  row_t             row_wdata;
  logic             cnt_inc;

  // output register
  logic             out_valid;
  status_t          out_status;
  logic [FOUND_W-1:0] out_found;
  row_t             out_row;
  logic [COUNT_W-1:0] out_count;

  assign req_word = '{
    mode:         req.mode,
    entity_index: req.entity_index,
    generation:   req.generation,
    kind_key:     req.kind_key,
    dimension:    req.dimension,
    buildable:    req.buildable,
    fac_state:    req.fac_state,
    dense_index:  req.dense_index
  };

  // row stage completes when the output register is free or being emptied
  assign finish    = (state == ST_ROW) && (!out_valid || rsp.ready);
  assign req.ready = (state == ST_IDLE) || finish;
  assign accept    = req.valid && req.ready;
  assign clr_last  = (32'(clr_addr) == SPARSE_DEPTH - 1);

  // sparse entry seen by the row stage, bypassing a same-address append
  assign sp_eff    = fwd_hit ? fwd_data : sparse_rd;
  assign row_raddr = (q.mode == MODE_READ) ? RAW'(q.dense_index) : sp_eff[RAW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_ROW;
      ST_ROW: begin
        if (finish) state_next = accept ? ST_LOOK : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // row stage: checks, result and memory write-back; also the sparse map clearing writes
  always_comb begin
    res_status = STS_OK;
    res_found  = '0;
    res_row    = '0;
    sp_we      = 1'b0;
    sp_waddr   = SAW'(q.entity_index);
    sp_wdata   = '0;
    row_we     = 1'b0;
    row_waddr  = sp[RAW-1:0];
    row_wdata  = row_rd;
    cnt_inc    = 1'b0;
    if (state == ST_CLEAR) begin
      sp_we    = 1'b1;
      sp_waddr = clr_addr;
    end else if (state == ST_ROW) begin
      case (q.mode)
        MODE_APPEND: begin
          if (q.generation == '0 || q.kind_key == '0) begin
            res_status = STS_INVALID;
          end else if (32'(q.entity_index) >= SPARSE_DEPTH) begin
            res_status = STS_RANGE;
          end else if (sp[RAW]) begin
            res_status = STS_DUP;
          end else if (32'(count) >= ROW_DEPTH) begin
            res_status = STS_FULL;
          end else begin
            res_found = FOUND_W'(count[RAW-1:0]);
            sp_we     = finish;
            sp_wdata  = {1'b1, count[RAW-1:0]};
            row_we    = finish;
            row_waddr = count[RAW-1:0];
            row_wdata = '{
              generation:   q.generation,
              entity_index: q.entity_index,
              kind_key:     q.kind_key,
              dimension:    q.dimension,
              buildable:    q.buildable,
              fac_state:    q.fac_state
            };
            cnt_inc   = finish;
          end
        end
        MODE_READ: begin
          if (32'(q.dense_index) >= 32'(count)) begin
            res_status = STS_RANGE;
          end else begin
            res_found = q.dense_index;
            res_row   = row_rd;
          end
        end
        MODE_FIND, MODE_SET_STATE: begin
          // ordered so that never-written rows are not looked at
          if (q.generation == '0 || 32'(q.entity_index) >= SPARSE_DEPTH) begin
            res_status = STS_MISS;
          end else if (!sp[RAW]) begin
            res_status = STS_MISS;
          end else if (32'(sp[RAW-1:0]) >= 32'(count)) begin
            res_status = STS_MISS;
          end else if (row_rd.generation != q.generation ||
                       row_rd.entity_index != q.entity_index) begin
            res_status = STS_MISS;
          end else begin
            res_found = FOUND_W'(sp[RAW-1:0]);
            if (q.mode == MODE_SET_STATE) begin
              row_we              = finish;
              row_wdata.fac_state = q.fac_state;
            end
          end
        end
        default: res_status = STS_INVALID;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cnt_inc) count <= count + 1'b1;
      if (finish) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      if (accept) fwd_hit <= sp_we && (state == ST_ROW) &&
                             (sp_waddr == SAW'(req.entity_index));
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q        <= req_word;
      fwd_data <= sp_wdata;
    end
    if (state == ST_LOOK) sp <= sp_eff;
    if (finish) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_row    <= res_row;
      out_count  <= COUNT_W'(32'(count) + 32'(cnt_inc));
    end
  end

  // sparse map memory
  always_ff @(posedge clk) begin
    if (sp_we) sparse_mem[sp_waddr] <= sp_wdata;
    if (accept) sparse_rd <= sparse_mem[SAW'(req.entity_index)];
  end

  // dense row memory
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (state == ST_LOOK) row_rd <= row_mem[row_raddr];
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.found_index      = out_found;
  assign rsp.row_entity_index = out_row.entity_index;
  assign rsp.row_generation   = out_row.generation;
  assign rsp.row_kind_key     = out_row.kind_key;
  assign rsp.row_dimension    = out_row.dimension;
  assign rsp.row_buildable    = out_row.buildable;
  assign rsp.row_state        = out_row.fac_state;
  assign rsp.row_count        = out_count;

endmodule

// File: rtl/gsst_checker.sv
// gsst_checker: port-level assertions on the sparse-set table, bound to the top level
// depends on gsst_pkg and generational_sparse_set_table
`timescale 1ns / 1ps

module gsst_checker #(
  parameter int unsigned ROW_DEPTH = gsst_pkg::ROW_DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input gsst_pkg::status_t            status,
  input logic [gsst_pkg::FOUND_W-1:0] found_index,
  input logic [gsst_pkg::GEN_W-1:0]   row_generation,
  input logic [gsst_pkg::KEY_W-1:0]   row_kind_key,
  input logic [gsst_pkg::COUNT_W-1:0] row_count
);
  import gsst_pkg::*;

  // sparse map clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during sparse map clearing");

  // stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found_index)
      && $stable(row_count))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(row_count) <= ROW_DEPTH)
    else $error("row count beyond table depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STS_OK |-> found_index == '0 && row_generation == '0
      && row_kind_key == '0)
    else $error("failed operation returned row data");

  // any row returned was appended with a valid key
  a_row_key: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && row_generation != '0 |-> row_kind_key != '0)
    else $error("row returned with zero kind key");

endmodule

bind generational_sparse_set_table gsst_checker #(.ROW_DEPTH(ROW_DEPTH)) u_gsst_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .found_index    (rsp.found_index),
  .row_generation (rsp.row_generation),
  .row_kind_key   (rsp.row_kind_key),
  .row_count      (rsp.row_count)
);

// File: tb/generational_sparse_set_table_test.sv
// generational_sparse_set_table_test: self-checking bench for the sparse-set table
// depends on gsst_pkg, gsst_if.sv and generational_sparse_set_table from rtl
// a shadow table predicts every response; random idling, stalls and long back-pressure
`timescale 1ns / 1ps

module generational_sparse_set_table_test;
  import gsst_pkg::*;

  localparam int unsigned ENTITIES   = SPARSE_DEPTH_DEF;
  localparam int unsigned ROWS       = ROW_DEPTH_DEF;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          HOLD_LEN   = 300;
  localparam int          MAX_REPORT = 10;

  // one response transaction, field for field as it leaves the block
  typedef struct packed {
    status_t            status;
    logic [FOUND_W-1:0] found_index;
    logic [IDX_W-1:0]   row_entity_index;
    logic [GEN_W-1:0]   row_generation;
    logic [KEY_W-1:0]   row_kind_key;
    logic [DIM_W-1:0]   row_dimension;
    logic               row_buildable;
    logic [FST_W-1:0]   row_state;
    logic [COUNT_W-1:0] row_count;
  } result_t;

  // shadow copy of the table plus the queue of responses still owed by the block
  class table_tracker;
    bit                 sparse_valid [ENTITIES];
    bit [FOUND_W-1:0]   sparse_slot  [ENTITIES];
    bit [IDX_W-1:0]     row_idx      [ROWS];
    bit [GEN_W-1:0]     row_gen      [ROWS];
    bit [KEY_W-1:0]     row_key      [ROWS];
    bit [DIM_W-1:0]     row_dim      [ROWS];
    bit                 row_bld      [ROWS];
    bit [FST_W-1:0]     row_fst      [ROWS];
    int unsigned        rows;
    result_t            awaited[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        by_status [8];

    // slot of a stored id whose generation matches, -1 on a miss
    function int locate(bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen);
      bit [FOUND_W-1:0] s;
      if (gen == '0 || !sparse_valid[idx]) return -1;
      s = sparse_slot[idx];
      if (32'(s) >= rows || row_gen[s] != gen || row_idx[s] != idx) return -1;
      return int'(s);
    endfunction

    function void note_request(req_t r);
      result_t          e;
      int               s;
      bit [FOUND_W-1:0] slot;
      e = '0;
      e.status = STS_OK;
      case (r.mode)
        MODE_APPEND: begin
          // entity index is 10 bits, so it can never run past the sparse map
          if (r.generation == '0 || r.kind_key == '0) e.status = STS_INVALID;
          else if (sparse_valid[r.entity_index]) e.status = STS_DUP;
          else if (rows >= ROWS) e.status = STS_FULL;
          else begin
            slot = rows[FOUND_W-1:0];
            row_idx[slot] = r.entity_index;
            row_gen[slot] = r.generation;
            row_key[slot] = r.kind_key;
            row_dim[slot] = r.dimension;
            row_bld[slot] = r.buildable;
            row_fst[slot] = r.fac_state;
            sparse_valid[r.entity_index] = 1'b1;
            sparse_slot[r.entity_index]  = slot;
            e.found_index = slot;
            rows++;
          end
        end
        MODE_READ: begin
          if (r.dense_index >= rows) e.status = STS_RANGE;
          else begin
            e.found_index      = r.dense_index;
            e.row_entity_index = row_idx[r.dense_index];
            e.row_generation   = row_gen[r.dense_index];
            e.row_kind_key     = row_key[r.dense_index];
            e.row_dimension    = row_dim[r.dense_index];
            e.row_buildable    = row_bld[r.dense_index];
            e.row_state        = row_fst[r.dense_index];
          end
        end
        default: begin
          s = locate(r.entity_index, r.generation);
          if (s < 0) e.status = STS_MISS;
          else begin
            if (r.mode == MODE_SET_STATE) row_fst[s[FOUND_W-1:0]] = r.fac_state;
            e.found_index = s[FOUND_W-1:0];
          end
        end
      endcase
      e.row_count = rows[COUNT_W-1:0];
      by_status[e.status]++;
      awaited.insert(awaited.size(), e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                   checked, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("response with nothing outstanding: status %0d count %0d",
                   got.status, got.row_count);
        return;
      end
      e = awaited.pop_front();
      compare_field("status", 32'(e.status), 32'(got.status));
      compare_field("found_index", 32'(e.found_index), 32'(got.found_index));
      compare_field("row_entity_index", 32'(e.row_entity_index),
                    32'(got.row_entity_index));
      compare_field("row_generation", 32'(e.row_generation), 32'(got.row_generation));
      compare_field("row_kind_key", e.row_kind_key, got.row_kind_key);
      compare_field("row_dimension", 32'(e.row_dimension), 32'(got.row_dimension));
      compare_field("row_buildable", 32'(e.row_buildable), 32'(got.row_buildable));
      compare_field("row_state", 32'(e.row_state), 32'(got.row_state));
      compare_field("row_count", 32'(e.row_count), 32'(got.row_count));
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;     // chance in a hundred that the sender skips a cycle
  int   stall_pct;    // chance in a hundred that the receiver drops ready
  int   hold_asked;   // bumped by the sender side to ask for one long hold-off
  int   hold_served;  // hold-offs the receiver has started
  int   hold_left;
  int   cycles;
  table_tracker book;

  gsst_req_if req_bus ();
  gsst_rsp_if rsp_bus ();

  generational_sparse_set_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #5 clk = ~clk;

  // watchdog over the whole run, including the clearing pass after reset
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, book.awaited.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // response monitor: a transaction completes at a rising edge with valid and ready high
  always @(posedge clk) begin
    result_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.status           = rsp_bus.status;
      got.found_index      = rsp_bus.found_index;
      got.row_entity_index = rsp_bus.row_entity_index;
      got.row_generation   = rsp_bus.row_generation;
      got.row_kind_key     = rsp_bus.row_kind_key;
      got.row_dimension    = rsp_bus.row_dimension;
      got.row_buildable    = rsp_bus.row_buildable;
      got.row_state        = rsp_bus.row_state;
      got.row_count        = rsp_bus.row_count;
      book.check_result(got);
    end
  end

  function automatic req_t make_req(mode_t m, bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen,
                                    bit [KEY_W-1:0] key, bit [DIM_W-1:0] dim, bit bld,
                                    bit [FST_W-1:0] fst, bit [DIX_W-1:0] dix);
    req_t r;
    r.mode         = m;
    r.entity_index = idx;
    r.generation   = gen;
    r.kind_key     = key;
    r.dimension    = dim;
    r.buildable    = bld;
    r.fac_state    = fst;
    r.dense_index  = dix;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  // valid is left high so back-to-back requests never toggle it within one step
  task automatic send_req(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= r.mode;
    req_bus.entity_index <= r.entity_index;
    req_bus.generation   <= r.generation;
    req_bus.kind_key     <= r.kind_key;
    req_bus.dimension    <= r.dimension;
    req_bus.buildable    <= r.buildable;
    req_bus.fac_state    <= r.fac_state;
    req_bus.dense_index  <= r.dense_index;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    book.note_request(r);
    @(negedge clk);
  endtask

  // sender goes quiet until every owed response has come back
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(negedge clk);
    while (book.awaited.size() != 0) @(negedge clk);
  endtask

  function automatic bit [IDX_W-1:0] free_entity();
    bit [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(0, ENTITIES - 1));
    while (book.sparse_valid[idx]) idx = IDX_W'($urandom_range(0, ENTITIES - 1));
    return idx;
  endfunction

  // mostly well-formed traffic against ids the table really holds, some noise
  task automatic run_random(int n);
    req_t r;
    int   pick;
    int   s;
    repeat (n) begin
      r = make_req(MODE_APPEND, IDX_W'($urandom_range(0, ENTITIES - 1)),
                   GEN_W'($urandom_range(0, 65535)), $urandom,
                   DIM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   FST_W'($urandom_range(0, 15)), DIX_W'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r.mode = MODE_APPEND;
        if ($urandom_range(0, 9) < 8 && book.rows < ROWS) begin
          r.entity_index = free_entity();
          if (r.generation == '0) r.generation = 16'd1;
          if (r.kind_key == '0) r.kind_key = 32'd1;
        end else begin
          // noise: invalid ids and keys, duplicates
          if ($urandom_range(0, 3) == 0) r.generation = '0;
          if ($urandom_range(0, 3) == 0) r.kind_key = '0;
        end
      end else if (pick < 50) begin
        r.mode = MODE_READ;
        if (book.rows > 0 && $urandom_range(0, 9) < 8)
          r.dense_index = DIX_W'($urandom_range(0, book.rows - 1));
      end else begin
        r.mode = (pick < 75) ? MODE_FIND : MODE_SET_STATE;
        if (book.rows > 0 && $urandom_range(0, 99) < 85) begin
          s = $urandom_range(0, book.rows - 1);
          r.entity_index = book.row_idx[s[FOUND_W-1:0]];
          r.generation   = book.row_gen[s[FOUND_W-1:0]];
          // stale generation of a live entity
          if ($urandom_range(0, 99) < 18)
            r.generation = r.generation ^ GEN_W'($urandom_range(1, 65535));
        end else if ($urandom_range(0, 4) == 0) begin
          r.generation = '0;
        end
      end
      send_req(r);
    end
  endtask

  initial begin
    book       = new();
    rst        = 1'b1;
    idle_pct   = 0;
    stall_pct  = 0;
    req_bus.valid        = 1'b0;
    req_bus.mode         = MODE_APPEND;
    req_bus.entity_index = '0;
    req_bus.generation   = '0;
    req_bus.kind_key     = '0;
    req_bus.dimension    = '0;
    req_bus.buildable    = 1'b0;
    req_bus.fac_state    = '0;
    req_bus.dense_index  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every mode, every rejection except full
    send_req(make_req(MODE_APPEND, 10'd0, 16'd1, 32'd1, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_APPEND, 10'd1023, 16'hffff, 32'hffff_ffff, 8'hff, 1'b1, 4'hf,
                      8'hff));
    send_req(make_req(MODE_APPEND, 10'd5, 16'd0, 32'd9, 8'd1, 1'b0, 4'd1, 8'd0));
    send_req(make_req(MODE_APPEND, 10'd6, 16'd9, 32'd0, 8'd1, 1'b0, 4'd1, 8'd0));
    // occupied index, other generation and same generation
    send_req(make_req(MODE_APPEND, 10'd0, 16'd7, 32'd3, 8'd2, 1'b1, 4'd2, 8'd0));
    send_req(make_req(MODE_APPEND, 10'd1023, 16'hffff, 32'd4, 8'd3, 1'b0, 4'd3, 8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd1));
    // read at the row count and at the top of the slot range
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd2));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'hff));
    send_req(make_req(MODE_FIND, 10'd0, 16'd1, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_FIND, 10'd0, 16'd2, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_FIND, 10'd1023, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_FIND, 10'd500, 16'd3, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_FIND, 10'd1023, 16'hffff, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_SET_STATE, 10'd1023, 16'hffff, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd1));
    send_req(make_req(MODE_SET_STATE, 10'd0, 16'd9, 32'd0, 8'd0, 1'b0, 4'hf, 8'd0));
    send_req(make_req(MODE_SET_STATE, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'hf, 8'd0));
    send_req(make_req(MODE_SET_STATE, 10'd0, 16'd1, 32'd0, 8'd0, 1'b0, 4'hf, 8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_APPEND, 10'd512, 16'h8000, 32'h8000_0000, 8'h80, 1'b1, 4'h8,
                      8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'd2));
    wait_drained();

    // random traffic through the idling and stall mixes
    run_random(330);
    idle_pct = 71;
    run_random(330);
    idle_pct  = 0;
    stall_pct = 71;
    run_random(330);
    idle_pct  = 38;
    stall_pct = 38;
    run_random(330);

    // long receiver hold-off while requests keep coming, so the input stalls
    idle_pct   = 0;
    stall_pct  = 0;
    hold_asked = hold_asked + 1;
    run_random(40);
    wait_drained();

    // fill the remaining rows, then appends must report a full table
    idle_pct  = 20;
    stall_pct = 20;
    while (book.rows < ROWS)
      send_req(make_req(MODE_APPEND, free_entity(), GEN_W'($urandom_range(1, 65535)),
                        $urandom_range(1, 32'hffff_ffff), DIM_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), FST_W'($urandom_range(0, 15)), 8'd0));
    repeat (3)
      send_req(make_req(MODE_APPEND, free_entity(), 16'd1, 32'd1, 8'd0, 1'b0, 4'd0, 8'd0));
    send_req(make_req(MODE_READ, 10'd0, 16'd0, 32'd0, 8'd0, 1'b0, 4'd0, 8'hff));
    run_random(60);

    // drain, then let the clock run on so that any stray response shows
    wait_drained();
    repeat (20) @(posedge clk);

    if (book.awaited.size() != 0) begin
      $display("%0d responses never arrived", book.awaited.size());
      book.mismatches++;
    end
    $display("checked %0d responses; table ended with %0d of %0d rows",
             book.checked, book.rows, ROWS);
    $display("status mix: ok %0d invalid %0d dup %0d range %0d miss %0d full %0d",
             book.by_status[STS_OK], book.by_status[STS_INVALID], book.by_status[STS_DUP],
             book.by_status[STS_RANGE], book.by_status[STS_MISS], book.by_status[STS_FULL]);
    if (book.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", book.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gsst_pkg.sv
rtl/gsst_if.sv
rtl/generational_sparse_set_table.sv
rtl/gsst_checker.sv
tb/generational_sparse_set_table_test.sv
